@@ rtl/core/hbg_pkg.sv @@
// Shared types, constants and helpers for the heightmap ground step block.
package hbg_pkg;

	localparam int GRID_MAX_DIM = 128;
	localparam int HEIGHT_WORDS = 16384;
	localparam int ADDR_W       = $clog2(HEIGHT_WORDS);
	localparam int IDX_W        = $clog2(GRID_MAX_DIM);
	localparam int FQ_DEPTH     = 4;
	localparam int FQ_PTR_W     = $clog2(FQ_DEPTH);
	localparam int FQ_CNT_W     = $clog2(FQ_DEPTH + 1);
	localparam int OQ_DEPTH     = 16;
	localparam int OQ_PTR_W     = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W     = $clog2(OQ_DEPTH + 1);

	localparam logic signed [31:0] FEET_OFFSET = 32'sd655360;

	typedef enum logic [1:0] {
		FUNC_LOAD   = 2'd0,
		FUNC_SAMPLE = 2'd1,
		FUNC_STEP   = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		REG_ORIGIN_X   = 3'd0,
		REG_ORIGIN_Z   = 3'd1,
		REG_INV_CELL_X = 3'd2,
		REG_INV_CELL_Z = 3'd3,
		REG_GRID_W     = 3'd4,
		REG_GRID_H     = 3'd5,
		REG_GRAVITY    = 3'd6,
		REG_TERMINAL   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_z;
		logic [31:0]        inv_x;
		logic [31:0]        inv_z;
		logic [7:0]         dim_w;   // already clamped to [2, GRID_MAX_DIM]
		logic [7:0]         dim_h;
		logic [30:0]        grav;
		logic [30:0]        term;
	} cfg_t;

	typedef struct packed {
		func_t              func;
		logic [13:0]        height_index;
		logic signed [31:0] height_value;
		logic signed [31:0] world_x;
		logic signed [31:0] world_z;
		logic signed [31:0] pos_y;
		logic signed [31:0] vel_y;
		logic [15:0]        time_step;
	} item_t;

	typedef struct packed {
		logic signed [31:0] ground_height;
		logic signed [31:0] new_pos_y;
		logic signed [31:0] new_vel_y;
		logic               grounded;
	} res_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			return 32'sh80000000;
		end else begin
			return $signed(v[31:0]);
		end
	endfunction

endpackage

@@ rtl/core/hbg_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module hbg_ram #(
	parameter int DEPTH = 16384,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/hbg_front.sv @@
// Front end: accepts items, drops the unused code, queues the rest.
module hbg_front import hbg_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	output logic  full,
	input  item_t in_item,
	output logic  q_valid,
	output item_t q_item,
	input  logic  q_pop
);

	item_t               buf_q [FQ_DEPTH];
	logic [FQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FQ_CNT_W-1:0] count_q;
	logic                wr;

	assign full    = (count_q == FQ_CNT_W'(FQ_DEPTH));
	assign q_valid = (count_q != '0);
	assign q_item  = buf_q[rd_ptr_q];
	// func code three is taken and forgotten
	assign wr      = push && !full && (in_item.func != FUNC_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (q_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + FQ_CNT_W'(wr) - FQ_CNT_W'(q_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) buf_q[wr_ptr_q] <= in_item;
	end

endmodule

@@ rtl/core/hbg_outq.sv @@
// Result queue in front of the output ports.
module hbg_outq import hbg_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr,
	input  res_t                wr_res,
	output logic                empty,
	input  logic                pop,
	output res_t                head,
	output logic [OQ_CNT_W-1:0] count
);

	res_t                buf_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [OQ_CNT_W-1:0] count_q;
	logic                rd;

	assign empty = (count_q == '0);
	assign head  = buf_q[rd_ptr_q];
	assign count = count_q;
	assign rd    = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rd) rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + OQ_CNT_W'(wr) - OQ_CNT_W'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) buf_q[wr_ptr_q] <= wr_res;
	end

endmodule

@@ rtl/core/hbg_back.sv @@
// Back end: grid mapping, corner reads, bilinear blend and vertical step pipeline.
module hbg_back import hbg_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  q_valid,
	input  item_t q_item,
	input  logic  credit_ok,
	output logic  q_pop,
	output logic  res_valid,
	output res_t  res
);

	typedef struct packed {
		func_t              func;
		logic signed [31:0] pos;
		logic signed [31:0] vel;
	} side_t;

	// stage 1
	logic               v_s1;
	func_t              func_s1;
	logic signed [32:0] dx_s1, dz_s1;
	logic [46:0]        gprod_s1;
	logic signed [31:0] py_s1, vy_s1;
	logic [15:0]        dt_s1;
	logic [13:0]        hidx_s1;
	logic signed [31:0] hval_s1;
	// stage 2
	logic               v_s2;
	func_t              func_s2;
	logic signed [49:0] pxh_s2, pxl_s2, pzh_s2, pzl_s2;
	logic signed [31:0] vel_s2, py_s2;
	logic [15:0]        dt_s2;
	logic [13:0]        hidx_s2;
	logic signed [31:0] hval_s2;
	// stage 3
	logic               v_s3;
	func_t              func_s3;
	logic signed [49:0] fx_s3, fz_s3, vdt_s3;
	logic signed [31:0] vel_s3, py_s3;
	logic [13:0]        hidx_s3;
	logic signed [31:0] hval_s3;
	// stage 4
	logic               v_s4;
	side_t              side_s4;
	logic [IDX_W-1:0]   ix_s4, iz_s4;
	logic signed [31:0] tx_s4, tz_s4;
	logic [13:0]        hidx_s4;
	logic signed [31:0] hval_s4;
	// stages 5..11
	logic               v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;
	side_t              side_s5, side_s6, side_s7, side_s8, side_s9, side_s10, side_s11;
	logic signed [31:0] tx_s5, tx_s6, tz_s5, tz_s6, tz_s7, tz_s8, tz_s9;
	logic signed [31:0] h00_s5, h10_s5, h01_s5, h11_s5;
	logic signed [31:0] h00_s6, h01_s6, h00_s7, h01_s7;
	logic signed [32:0] d0_s6, d1_s6;
	logic signed [48:0] m0h_s7, m1h_s7, mzh_s10;
	logic signed [49:0] m0l_s7, m1l_s7, mzl_s10;
	logic signed [31:0] h0_s8, h1_s8, h0_s9, h0_s10;
	logic signed [32:0] dd_s9;
	logic signed [31:0] ground_s11;
	// stage 12
	logic               v_s12;
	res_t               res_s12;

	logic               step_s1;
	logic signed [32:0] vel_raw, vel_lim;
	logic signed [33:0] irx, irz;
	logic [IDX_W-1:0]   ix_c, iz_c;
	logic [7:0]         lim_w, lim_h;
	logic [ADDR_W-1:0]  a00, a10, a01, a11;
	logic               ram_we;
	logic [31:0]        rd00, rd10, rd01, rd11;
	logic signed [31:0] desired;

	assign q_pop = q_valid && ((q_item.func == FUNC_LOAD) || credit_ok);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6} <= '0;
			{v_s7, v_s8, v_s9, v_s10, v_s11, v_s12} <= '0;
		end else begin
			v_s1  <= q_pop;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4 && (side_s4.func != FUNC_LOAD);
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
		end
	end

	// velocity after gravity and terminal limit
	assign step_s1 = (func_s1 == FUNC_STEP);
	assign vel_raw = 33'(vy_s1) - $signed({2'b00, gprod_s1[46:16]});
	assign vel_lim = (vel_raw < -$signed({2'b00, cfg.term})) ? -$signed({2'b00, cfg.term})
	                                                       : vel_raw;

	// cell index clamp
	assign irx   = 34'(fx_s3 >>> 16);
	assign irz   = 34'(fz_s3 >>> 16);
	assign lim_w = cfg.dim_w - 8'd2;
	assign lim_h = cfg.dim_h - 8'd2;

	always_comb begin
		if (irx[33]) ix_c = '0;
		else if (irx > $signed({26'd0, lim_w})) ix_c = IDX_W'(lim_w);
		else ix_c = IDX_W'(irx);
		if (irz[33]) iz_c = '0;
		else if (irz > $signed({26'd0, lim_h})) iz_c = IDX_W'(lim_h);
		else iz_c = IDX_W'(irz);
	end

	// corner addresses
	assign a00    = ADDR_W'(iz_s4 * cfg.dim_w) + ADDR_W'(ix_s4);
	assign a10    = a00 + 1'b1;
	assign a01    = a00 + ADDR_W'(cfg.dim_w);
	assign a11    = a01 + 1'b1;
	assign ram_we = v_s4 && (side_s4.func == FUNC_LOAD);

	hbg_ram #(.DEPTH(HEIGHT_WORDS), .WIDTH(32)) u_ram00 (
		.clk(clk), .we(ram_we), .waddr(hidx_s4), .wdata(hval_s4), .raddr(a00), .rdata(rd00)
	);
	hbg_ram #(.DEPTH(HEIGHT_WORDS), .WIDTH(32)) u_ram10 (
		.clk(clk), .we(ram_we), .waddr(hidx_s4), .wdata(hval_s4), .raddr(a10), .rdata(rd10)
	);
	hbg_ram #(.DEPTH(HEIGHT_WORDS), .WIDTH(32)) u_ram01 (
		.clk(clk), .we(ram_we), .waddr(hidx_s4), .wdata(hval_s4), .raddr(a01), .rdata(rd01)
	);
	hbg_ram #(.DEPTH(HEIGHT_WORDS), .WIDTH(32)) u_ram11 (
		.clk(clk), .we(ram_we), .waddr(hidx_s4), .wdata(hval_s4), .raddr(a11), .rdata(rd11)
	);

	assign h00_s5 = $signed(rd00);
	assign h10_s5 = $signed(rd10);
	assign h01_s5 = $signed(rd01);
	assign h11_s5 = $signed(rd11);

	assign desired = sat32(64'(ground_s11) + 64'(FEET_OFFSET));

	always_ff @(posedge clk) begin
		// s1: offsets from origin, gravity impulse
		func_s1  <= q_item.func;
		dx_s1    <= 33'(q_item.world_x) - 33'(cfg.origin_x);
		dz_s1    <= 33'(q_item.world_z) - 33'(cfg.origin_z);
		gprod_s1 <= cfg.grav * q_item.time_step;
		py_s1    <= q_item.pos_y;
		vy_s1    <= q_item.vel_y;
		dt_s1    <= q_item.time_step;
		hidx_s1  <= q_item.height_index;
		hval_s1  <= q_item.height_value;
		// s2: scale by reciprocal cell size, split in two 16-bit halves
		func_s2  <= func_s1;
		pxh_s2   <= dx_s1 * $signed({1'b0, cfg.inv_x[31:16]});
		pxl_s2   <= dx_s1 * $signed({1'b0, cfg.inv_x[15:0]});
		pzh_s2   <= dz_s1 * $signed({1'b0, cfg.inv_z[31:16]});
		pzl_s2   <= dz_s1 * $signed({1'b0, cfg.inv_z[15:0]});
		vel_s2   <= step_s1 ? 32'(vel_lim) : vy_s1;
		py_s2    <= py_s1;
		dt_s2    <= dt_s1;
		hidx_s2  <= hidx_s1;
		hval_s2  <= hval_s1;
		// s3: grid coordinates, displacement product
		func_s3  <= func_s2;
		fx_s3    <= pxh_s2 + (pxl_s2 >>> 16);
		fz_s3    <= pzh_s2 + (pzl_s2 >>> 16);
		vdt_s3   <= vel_s2 * $signed({1'b0, dt_s2});
		vel_s3   <= vel_s2;
		py_s3    <= py_s2;
		hidx_s3  <= hidx_s2;
		hval_s3  <= hval_s2;
		// s4: cell index, fraction, moved position
		side_s4.func <= func_s3;
		side_s4.vel  <= vel_s3;
		side_s4.pos  <= (func_s3 == FUNC_STEP) ? sat32(64'(py_s3) + 64'(vdt_s3 >>> 16)) : py_s3;
		ix_s4   <= ix_c;
		iz_s4   <= iz_c;
		tx_s4   <= sat32(64'(fx_s3 - $signed(50'({ix_c, 16'd0}))));
		tz_s4   <= sat32(64'(fz_s3 - $signed(50'({iz_c, 16'd0}))));
		hidx_s4 <= hidx_s3;
		hval_s4 <= hval_s3;
		// s5: corner words arrive
		side_s5 <= side_s4;
		tx_s5   <= tx_s4;
		tz_s5   <= tz_s4;
		// s6: row differences
		side_s6 <= side_s5;
		tx_s6   <= tx_s5;
		tz_s6   <= tz_s5;
		d0_s6   <= 33'(h10_s5) - 33'(h00_s5);
		d1_s6   <= 33'(h11_s5) - 33'(h01_s5);
		h00_s6  <= h00_s5;
		h01_s6  <= h01_s5;
		// s7: row products
		side_s7 <= side_s6;
		tz_s7   <= tz_s6;
		m0h_s7  <= d0_s6 * $signed(tx_s6[31:16]);
		m0l_s7  <= d0_s6 * $signed({1'b0, tx_s6[15:0]});
		m1h_s7  <= d1_s6 * $signed(tx_s6[31:16]);
		m1l_s7  <= d1_s6 * $signed({1'b0, tx_s6[15:0]});
		h00_s7  <= h00_s6;
		h01_s7  <= h01_s6;
		// s8: row heights
		side_s8 <= side_s7;
		tz_s8   <= tz_s7;
		h0_s8   <= sat32(64'(h00_s7) + 64'(m0h_s7) + 64'(m0l_s7 >>> 16));
		h1_s8   <= sat32(64'(h01_s7) + 64'(m1h_s7) + 64'(m1l_s7 >>> 16));
		// s9: column difference
		side_s9 <= side_s8;
		tz_s9   <= tz_s8;
		dd_s9   <= 33'(h1_s8) - 33'(h0_s8);
		h0_s9   <= h0_s8;
		// s10: column products
		side_s10 <= side_s9;
		mzh_s10  <= dd_s9 * $signed(tz_s9[31:16]);
		mzl_s10  <= dd_s9 * $signed({1'b0, tz_s9[15:0]});
		h0_s10   <= h0_s9;
		// s11: ground height
		side_s11   <= side_s10;
		ground_s11 <= sat32(64'(h0_s10) + 64'(mzh_s10) + 64'(mzl_s10 >>> 16));
		// s12: ground snap
		res_s12.ground_height <= ground_s11;
		if ((side_s11.func == FUNC_STEP) && (side_s11.pos < desired)) begin
			res_s12.new_pos_y <= desired;
			res_s12.new_vel_y <= '0;
			res_s12.grounded  <= 1'b1;
		end else begin
			res_s12.new_pos_y <= side_s11.pos;
			res_s12.new_vel_y <= side_s11.vel;
			res_s12.grounded  <= 1'b0;
		end
	end

	assign res_valid = v_s12;
	assign res       = res_s12;

endmodule

@@ rtl/core/heightmap_bilinear_ground_step.sv @@
// Top level of the heightmap ground block: config registers, front queue, pipeline, result queue.
// Heightmap ground step. Items enter through a push/full queue and results leave through an
// empty/pop queue; one item is taken per clock while the input queue is not full, and results
// come out in order. func 0 writes one Q16.16 height word (no result), func 1 returns the
// bilinear ground height at world x,z, func 2 applies gravity over time_step, caps the fall at
// terminal_speed, moves pos_y and snaps it onto the ground plus a 10.0 feet offset when below
// it; func 3 is swallowed. The pipeline never stalls: it is fed from a four-entry input queue,
// and a sample or step issues only while a slot is reserved in the sixteen-entry result queue.
// An item runs from the input queue through stages s1 to s12 into the result queue. The height
// store is held four times, one copy per bilinear corner, so all corners are read in the same
// cycle; loads write every copy in the same stage that samples read, which keeps loads and
// samples in item order. The store has no reset and no clearing pass: reading a word that was
// never loaded gives an arbitrary height. Configuration writes land at once and must only
// happen while the block is idle.
module heightmap_bilinear_ground_step import hbg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// item side
	input  logic               push,
	output logic               full,
	input  logic [1:0]         func,
	input  logic [13:0]        height_index,
	input  logic signed [31:0] height_value,
	input  logic signed [31:0] world_x,
	input  logic signed [31:0] world_z,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] vel_y,
	input  logic [15:0]        time_step,
	// result side
	output logic               empty,
	input  logic               pop,
	output logic signed [31:0] ground_height,
	output logic signed [31:0] new_pos_y,
	output logic signed [31:0] new_vel_y,
	output logic               grounded,
	// configuration
	input  logic               wr_en,
	input  logic [2:0]         wr_index,
	input  logic [31:0]        wr_data
);

	logic signed [31:0]  origin_x_q, origin_z_q;
	logic [31:0]         inv_x_q, inv_z_q;
	logic [7:0]          grid_w_q, grid_h_q;
	logic [30:0]         grav_q, term_q;
	cfg_t                cfg;
	item_t               in_item, q_item;
	logic                q_valid, q_pop;
	logic                res_valid;
	res_t                res, head;
	logic [OQ_CNT_W-1:0] oq_count;
	logic [OQ_CNT_W-1:0] credit_q;   // result slots reserved by items in flight or waiting
	logic                credit_ok, take_res, give_res;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_z_q <= '0;
			inv_x_q    <= 32'd65536;
			inv_z_q    <= 32'd65536;
			grid_w_q   <= 8'd128;
			grid_h_q   <= 8'd128;
			grav_q     <= 31'd1310720;
			term_q     <= 31'd3276800;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_ORIGIN_X:   origin_x_q <= $signed(wr_data);
				REG_ORIGIN_Z:   origin_z_q <= $signed(wr_data);
				REG_INV_CELL_X: inv_x_q    <= wr_data;
				REG_INV_CELL_Z: inv_z_q    <= wr_data;
				REG_GRID_W:     grid_w_q   <= wr_data[7:0];
				REG_GRID_H:     grid_h_q   <= wr_data[7:0];
				REG_GRAVITY:    grav_q     <= wr_data[30:0];
				REG_TERMINAL:   term_q     <= wr_data[30:0];
				default: ;
			endcase
		end
	end

	// grid sizes outside [2, max] act as clamped
	always_comb begin
		cfg.origin_x = origin_x_q;
		cfg.origin_z = origin_z_q;
		cfg.inv_x    = inv_x_q;
		cfg.inv_z    = inv_z_q;
		cfg.grav     = grav_q;
		cfg.term     = term_q;
		if (grid_w_q < 8'd2) cfg.dim_w = 8'd2;
		else if (grid_w_q > 8'(GRID_MAX_DIM)) cfg.dim_w = 8'(GRID_MAX_DIM);
		else cfg.dim_w = grid_w_q;
		if (grid_h_q < 8'd2) cfg.dim_h = 8'd2;
		else if (grid_h_q > 8'(GRID_MAX_DIM)) cfg.dim_h = 8'(GRID_MAX_DIM);
		else cfg.dim_h = grid_h_q;
	end

	always_comb begin
		in_item.func         = func_t'(func);
		in_item.height_index = height_index;
		in_item.height_value = height_value;
		in_item.world_x      = world_x;
		in_item.world_z      = world_z;
		in_item.pos_y        = pos_y;
		in_item.vel_y        = vel_y;
		in_item.time_step    = time_step;
	end

	hbg_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_item(in_item),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
	);

	hbg_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .q_valid(q_valid), .q_item(q_item),
		.credit_ok(credit_ok), .q_pop(q_pop), .res_valid(res_valid), .res(res)
	);

	hbg_outq u_outq (
		.clk(clk), .arst_n(arst_n), .wr(res_valid), .wr_res(res), .empty(empty),
		.pop(pop), .head(head), .count(oq_count)
	);

	// slot reservation: a sample or step only issues if its result has a place to land
	assign credit_ok = (credit_q < OQ_CNT_W'(OQ_DEPTH));
	assign take_res  = q_pop && (q_item.func != FUNC_LOAD);
	assign give_res  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			credit_q <= credit_q + OQ_CNT_W'(take_res) - OQ_CNT_W'(give_res);
		end
	end

	assign ground_height = head.ground_height;
	assign new_pos_y     = head.new_pos_y;
	assign new_vel_y     = head.new_vel_y;
	assign grounded      = head.grounded;

	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		credit_q <= OQ_CNT_W'(OQ_DEPTH))
		else $error("result slot reservations exceed queue depth");

	a_queue_within_credit: assert property (@(posedge clk) disable iff (!arst_n)
		oq_count <= credit_q)
		else $error("result queue holds more beats than reserved");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (oq_count < OQ_CNT_W'(OQ_DEPTH)) || give_res)
		else $error("result written into a full queue");

	a_pop_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("issue from an empty front queue");

endmodule

@@ test/heightmap_bilinear_ground_step_tb.sv @@
// Testbench for heightmap_bilinear_ground_step: scoreboard, stimulus and checks.
`timescale 1ns / 1ps

module heightmap_bilinear_ground_step_tb;
	import hbg_pkg::*;

	// Scoreboard with its own copy of the registers and the height store.
	// It predicts each result as an input beat is accepted and checks results in order.
	class ground_scoreboard;
		logic signed [31:0] org_x, org_z;
		logic [31:0]        inv_x, inv_z;
		logic [7:0]         gw, gh;
		logic [30:0]        grav, term;
		logic [31:0]        heights [HEIGHT_WORDS];
		res_t               want_q[$];
		int                 errors;
		int                 results_seen;
		int                 grounded_seen;
		int                 items_seen;

		function new();
			org_x = 0;
			org_z = 0;
			inv_x = 32'd65536;
			inv_z = 32'd65536;
			gw = 8'd128;
			gh = 8'd128;
			grav = 31'd1310720;
			term = 31'd3276800;
			errors = 0;
			results_seen = 0;
			grounded_seen = 0;
			items_seen = 0;
		endfunction

		function void set_reg(reg_idx_t r, logic [31:0] d);
			case (r)
				REG_ORIGIN_X:   org_x = d;
				REG_ORIGIN_Z:   org_z = d;
				REG_INV_CELL_X: inv_x = d;
				REG_INV_CELL_Z: inv_z = d;
				REG_GRID_W:     gw = d[7:0];
				REG_GRID_H:     gh = d[7:0];
				REG_GRAVITY:    grav = d[30:0];
				REG_TERMINAL:   term = d[30:0];
				default: ;
			endcase
		endfunction

		// floor division by 2^16 on a signed value
		function longint floor16(longint v);
			return v >>> 16;
		endfunction

		function longint clip32(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		// exact grid coordinate (w - origin) * inv / 2^16, rounded toward minus infinity
		function longint to_grid(longint w, longint o, logic [31:0] inv);
			longint d, m, ip, fp;
			d = w - o;
			m = (d < 0) ? -d : d;
			ip = m * longint'({48'd0, inv[31:16]});
			fp = m * longint'({48'd0, inv[15:0]});
			if (d >= 0) return ip + (fp >>> 16);
			return -(ip + ((fp + 65535) >>> 16));
		endfunction

		function int dim_of(logic [7:0] d);
			if (d < 2) return 2;
			if (d > GRID_MAX_DIM) return GRID_MAX_DIM;
			return d;
		endfunction

		// corner addresses (00, 10, 01, 11) and fractions of a world point
		function void locate(input logic signed [31:0] wx, input logic signed [31:0] wz,
				output int addr [4], output longint tx, output longint tz);
			longint fx, fz, ix, iz;
			int w, h;
			w = dim_of(gw);
			h = dim_of(gh);
			fx = to_grid(wx, org_x, inv_x);
			fz = to_grid(wz, org_z, inv_z);
			ix = floor16(fx);
			iz = floor16(fz);
			if (ix < 0) ix = 0;
			if (ix > w - 2) ix = w - 2;
			if (iz < 0) iz = 0;
			if (iz > h - 2) iz = h - 2;
			tx = clip32(fx - ix * 65536);
			tz = clip32(fz - iz * 65536);
			addr[0] = int'((iz * w + ix) % HEIGHT_WORDS);
			addr[1] = int'((iz * w + ix + 1) % HEIGHT_WORDS);
			addr[2] = int'(((iz + 1) * w + ix) % HEIGHT_WORDS);
			addr[3] = int'(((iz + 1) * w + ix + 1) % HEIGHT_WORDS);
		endfunction

		function longint blend(longint a, longint b, longint t);
			return clip32(a + floor16((b - a) * t));
		endfunction

		function longint ground_at(logic signed [31:0] wx, logic signed [31:0] wz);
			int     a [4];
			longint tx, tz, h0, h1;
			locate(wx, wz, a, tx, tz);
			h0 = blend(longint'($signed(heights[a[0]])), longint'($signed(heights[a[1]])), tx);
			h1 = blend(longint'($signed(heights[a[2]])), longint'($signed(heights[a[3]])), tx);
			return blend(h0, h1, tz);
		endfunction

		function void note_item(item_t it);
			res_t   r;
			longint g, pos, vel, dt, floor_y;
			items_seen++;
			case (it.func)
				FUNC_LOAD: heights[it.height_index] = it.height_value;
				FUNC_SAMPLE, FUNC_STEP: begin
					g = ground_at(it.world_x, it.world_z);
					pos = it.pos_y;
					vel = it.vel_y;
					r.grounded = 1'b0;
					if (it.func == FUNC_STEP) begin
						dt = it.time_step;
						vel = vel - (longint'(grav) * dt) / 65536;
						if (vel < -longint'(term)) vel = -longint'(term);
						pos = clip32(pos + floor16(vel * dt));
						floor_y = clip32(g + longint'(FEET_OFFSET));
						if (pos < floor_y) begin
							pos = floor_y;
							vel = 0;
							r.grounded = 1'b1;
						end
					end
					r.ground_height = g[31:0];
					r.new_pos_y = pos[31:0];
					r.new_vel_y = vel[31:0];
					want_q.push_back(r);
				end
				default: ;
			endcase
		endfunction

		function void check_result(res_t got);
			res_t w;
			if (want_q.size() == 0) begin
				$display("%t unexpected result beat: ground %h pos %h vel %h grounded %b",
					$realtime, got.ground_height, got.new_pos_y, got.new_vel_y, got.grounded);
				errors++;
				return;
			end
			w = want_q.pop_front();
			results_seen++;
			if (got.grounded) grounded_seen++;
			if (got.ground_height !== w.ground_height) begin
				$display("%t ground_height mismatch: expected %h actual %h",
					$realtime, w.ground_height, got.ground_height);
				errors++;
			end
			if (got.new_pos_y !== w.new_pos_y) begin
				$display("%t new_pos_y mismatch: expected %h actual %h",
					$realtime, w.new_pos_y, got.new_pos_y);
				errors++;
			end
			if (got.new_vel_y !== w.new_vel_y) begin
				$display("%t new_vel_y mismatch: expected %h actual %h",
					$realtime, w.new_vel_y, got.new_vel_y);
				errors++;
			end
			if (got.grounded !== w.grounded) begin
				$display("%t grounded mismatch: expected %b actual %b",
					$realtime, w.grounded, got.grounded);
				errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	logic [1:0]         func;
	logic [13:0]        height_index;
	logic signed [31:0] height_value;
	logic signed [31:0] world_x;
	logic signed [31:0] world_z;
	logic signed [31:0] pos_y;
	logic signed [31:0] vel_y;
	logic [15:0]        time_step;
	logic               empty;
	logic               pop;
	logic signed [31:0] ground_height;
	logic signed [31:0] new_pos_y;
	logic signed [31:0] new_vel_y;
	logic               grounded;
	logic               wr_en;
	logic [2:0]         wr_index;
	logic [31:0]        wr_data;

	heightmap_bilinear_ground_step u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.func         (func),
		.height_index (height_index),
		.height_value (height_value),
		.world_x      (world_x),
		.world_z      (world_z),
		.pos_y        (pos_y),
		.vel_y        (vel_y),
		.time_step    (time_step),
		.empty        (empty),
		.pop          (pop),
		.ground_height(ground_height),
		.new_pos_y    (new_pos_y),
		.new_vel_y    (new_vel_y),
		.grounded     (grounded),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data)
	);

	ground_scoreboard sb;

	// which height words hold a loaded value; a sample never reads any other word
	bit loaded [HEIGHT_WORDS];
	int send_idle_pct;
	int recv_idle_pct;
	bit long_hold_req;
	int hold_cnt;
	int full_stalls;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Hard stop: well above the slowest legal run (a few thousand beats at heavy idling).
	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	// Result side: take a beat when pop and !empty meet at an edge, then choose the next pop.
	// A long hold-off keeps pop low so the result queue fills and full pushes back on the sender.
	always @(posedge clk) begin
		res_t got;
		if (arst_n && pop && !empty) begin
			got.ground_height = ground_height;
			got.new_pos_y = new_pos_y;
			got.new_vel_y = new_vel_y;
			got.grounded = grounded;
			sb.check_result(got);
		end
		if (arst_n && push && full)
			full_stalls++;
		if (long_hold_req) begin
			long_hold_req = 1'b0;
			hold_cnt = 400;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic item_t make_item(func_t f, logic [13:0] idx, logic [31:0] hv,
			logic [31:0] wx, logic [31:0] wz, logic [31:0] py, logic [31:0] vy, logic [15:0] dt);
		item_t it;
		it.func = f;
		it.height_index = idx;
		it.height_value = hv;
		it.world_x = wx;
		it.world_z = wz;
		it.pos_y = py;
		it.vel_y = vy;
		it.time_step = dt;
		return it;
	endfunction

	// Offer one beat and hold it until accepted; then maybe drop push for a random gap.
	task automatic send(item_t it);
		int gap;
		func <= it.func;
		height_index <= it.height_index;
		height_value <= it.height_value;
		world_x <= it.world_x;
		world_z <= it.world_z;
		pos_y <= it.pos_y;
		vel_y <= it.vel_y;
		time_step <= it.time_step;
		push <= 1'b1;
		do
			@(posedge clk);
		while (full);
		sb.note_item(it);
		if (it.func == FUNC_LOAD)
			loaded[it.height_index] = 1'b1;
		gap = 0;
		if ($urandom_range(99) < send_idle_pct)
			gap = $urandom_range(4, 1);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic load_word(int idx, logic [31:0] hv);
		send(make_item(FUNC_LOAD, idx[13:0], hv, $urandom, $urandom, $urandom, $urandom, $urandom));
	endtask

	// random height: mostly gentle terrain, sometimes any 32-bit word
	function automatic logic [31:0] rand_height();
		if ($urandom_range(9) == 0)
			return $urandom;
		return $signed($urandom_range(2 * 1310720)) - 1310720;
	endfunction

	// Sample or step: first load any corner word that was never written.
	task automatic query(func_t f, logic [31:0] wx, logic [31:0] wz, logic [31:0] py,
			logic [31:0] vy, logic [15:0] dt);
		int     a [4];
		longint tx, tz;
		sb.locate(wx, wz, a, tx, tz);
		foreach (a[k])
			if (!loaded[a[k]])
				load_word(a[k], rand_height());
		send(make_item(f, $urandom, $urandom, wx, wz, py, vy, dt));
	endtask

	// world coordinate that lands near grid coordinate g (Q16.16) for the given axis
	function automatic logic [31:0] world_for(longint g, logic [31:0] org, logic [31:0] inv);
		longint w;
		if (inv == 0)
			return $urandom;
		w = longint'($signed(org)) + ((g <<< 16) / longint'({32'd0, inv}));
		return w[31:0];
	endfunction

	// One random beat: mostly well-aimed samples and steps, some loads and noise.
	task automatic random_beat();
		int          sel, w, h;
		longint      gx, gz, gnd;
		logic [31:0] wx, wz, py, vy;
		logic [15:0] dt;
		func_t       f;
		w = sb.dim_of(sb.gw);
		h = sb.dim_of(sb.gh);
		sel = $urandom_range(99);
		if (sel < 8) begin
			load_word($urandom_range(HEIGHT_WORDS - 1), rand_height());
		end else if (sel < 11) begin
			send(make_item(FUNC_NONE, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom));
		end else begin
			f = (sel < 45) ? FUNC_SAMPLE : FUNC_STEP;
			if ($urandom_range(9) < 8) begin
				// grid coordinate from two cells below the low edge to one cell beyond the high edge
				gx = longint'($urandom_range((w + 2) * 65536)) - 2 * 65536;
				gz = longint'($urandom_range((h + 2) * 65536)) - 2 * 65536;
				wx = world_for(gx, sb.org_x, sb.inv_x);
				wz = world_for(gz, sb.org_z, sb.inv_z);
			end else begin
				wx = $urandom;
				wz = $urandom;
			end
			dt = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4369, 546));
			if ($urandom_range(5) == 0) begin
				py = $urandom;
				vy = $urandom;
			end else begin
				// entity near the ground so both the snap and the free fall happen
				query(FUNC_SAMPLE, wx, wz, 0, 0, 0);
				gnd = sb.ground_at(wx, wz);
				py = 32'(sb.clip32(gnd + 655360 + longint'($urandom_range(12 * 65536))
					- 4 * 65536));
				vy = $signed($urandom_range(80 * 65536)) - 60 * 65536;
			end
			query(f, wx, wz, py, vy, dt);
		end
	endtask

	task automatic write_reg(reg_idx_t r, logic [31:0] d);
		wr_en <= 1'b1;
		wr_index <= r;
		wr_data <= d;
		sb.set_reg(r, d);
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// Stop offering, wait for every expected beat, then let the pipeline clear of loads.
	task automatic drain();
		push <= 1'b0;
		while (sb.want_q.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	initial begin
		logic [31:0] cfg [8];
		sb = new();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		long_hold_req = 1'b0;
		hold_cnt = 0;
		full_stalls = 0;
		arst_n <= 1'b0;
		push <= 1'b0;
		pop <= 1'b0;
		func <= FUNC_NONE;
		height_index <= '0;
		height_value <= '0;
		world_x <= '0;
		world_z <= '0;
		pos_y <= '0;
		vel_y <= '0;
		time_step <= '0;
		wr_en <= 1'b0;
		wr_index <= REG_ORIGIN_X;
		wr_data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part on reset registers: extreme heights, all functions, edge cells.
		load_word(0, 32'h7fffffff);
		load_word(1, 32'h80000000);
		load_word(128, 32'h00000000);
		load_word(129, 32'h12345678);
		load_word(HEIGHT_WORDS - 1, 32'hffffffff);
		query(FUNC_SAMPLE, 32'h00008000, 32'h00008000, 32'h7fffffff, 32'h80000000, 16'hffff);
		query(FUNC_SAMPLE, 32'h00000000, 32'h00000000, 0, 0, 0);
		query(FUNC_SAMPLE, -32'sd6553600, -32'sd6553600, 0, 0, 0);  // off the low edges
		query(FUNC_SAMPLE, 32'sd32784384, 32'sd45924352, 0, 0, 0);  // off the high edges
		query(FUNC_SAMPLE, 32'h007fc000, 32'h007f4000, 0, 0, 0);    // last cell
		send(make_item(FUNC_NONE, '1, '1, '1, '1, '1, '1, '1));
		query(FUNC_STEP, 32'h00018000, 32'h00018000, 32'sd6553600, 0, 16'd6554);
		query(FUNC_STEP, 32'h00018000, 32'h00018000, 32'h7fffffff, 32'h80000000, 16'hffff);
		query(FUNC_STEP, 32'h00018000, 32'h00018000, 32'h80000000, 32'h7fffffff, 16'hffff);
		query(FUNC_STEP, 32'h00008000, 32'h00008000, 32'h7fffffff, 32'h7fffffff, 16'd0);
		query(FUNC_STEP, 32'h00008000, 32'h00008000, 32'h80000000, 32'h00000000, 16'd1);
		query(FUNC_STEP, 32'h00018000, 32'h00018000, 32'sd100000000, -32'sd65536000, 16'hffff);
		drain();

		// Register sets: ordinary, extremes, tiny grid, and random.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: cfg = '{32'hfffb0000, 32'h00034000, 32'h00008000, 32'h00020000,
					32'd16, 32'd9, 32'd642253, 32'd1966080};
				1: cfg = '{32'h80000000, 32'h7fffffff, 32'hffffffff, 32'h00000000,
					32'd0, 32'd255, 32'h7fffffff, 32'd0};
				2: cfg = '{32'h7fffffff, 32'h80000000, 32'h00000000, 32'hffffffff,
					32'd1, 32'd2, 32'd0, 32'h7fffffff};
				3: cfg = '{32'h00000000, 32'h00000000, 32'h00010000, 32'h00010000,
					32'd128, 32'd128, 32'd1310720, 32'd3276800};
				default: begin
					cfg[0] = $signed($urandom_range(200 * 65536)) - 100 * 65536;
					cfg[1] = $signed($urandom_range(200 * 65536)) - 100 * 65536;
					cfg[2] = $urandom_range(4 * 65536, 4096);
					cfg[3] = $urandom_range(4 * 65536, 4096);
					cfg[4] = $urandom_range(200);
					cfg[5] = $urandom_range(200);
					cfg[6] = $urandom_range(60 * 65536);
					cfg[7] = $urandom_range(80 * 65536);
				end
			endcase
			for (int r = 0; r < 8; r++)
				write_reg(reg_idx_t'(r), cfg[r]);
			// idling: sender light and receiver heavy, then swapped, then none
			send_idle_pct = (ph < 2) ? 20 : (ph < 4) ? 68 : 0;
			recv_idle_pct = (ph < 2) ? 68 : (ph < 4) ? 20 : 0;
			if (ph == 0 || ph == 4)
				long_hold_req = 1'b1;
			// a stretch with no idling on either side inside each phase
			for (int n = 0; n < 90; n++) begin
				if (n == 68) begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
				random_beat();
			end
			drain();
		end

		$display("Covered %0d input beats and %0d result beats (%0d snapped to ground),",
			sb.items_seen, sb.results_seen, sb.grounded_seen);
		$display("seven register sets with extremes, and %0d cycles of input back-pressure.",
			full_stalls);
		if (sb.errors == 0 && sb.want_q.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/hbg_pkg.sv
rtl/core/hbg_ram.sv
rtl/core/hbg_front.sv
rtl/core/hbg_outq.sv
rtl/core/hbg_back.sv
rtl/core/heightmap_bilinear_ground_step.sv
test/heightmap_bilinear_ground_step_tb.sv
